@@ hdl/lucas_binomial_divisibility_top_defines.svh @@
// Assertion macros for the Lucas divisibility block.
// Used by lucas_binomial_divisibility_top; no other dependencies.
`ifndef LUCAS_BINOMIAL_DIVISIBILITY_TOP_DEFINES_SVH
`define LUCAS_BINOMIAL_DIVISIBILITY_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBD_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LBD_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lbd_pkg.sv @@
// Shared types and constants for the Lucas divisibility block.
// No dependencies.
package lbd_pkg;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 8;
    localparam int FIELD_W     = 64;
    localparam int CFG_W       = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_DONE
    } lbd_state_t;

    // Per-lane control from the sequencer
    typedef struct packed {
        logic load;   // take a new value, clear remainder
        logic clear;  // clear remainder before a digit division
        logic shift;  // one restoring-division bit step
    } lbd_lane_ctl_t;

    // Sequencer status to the stream wrapper
    typedef struct packed {
        logic idle;
        logic done;
        logic result;
    } lbd_status_t;

endpackage

@@ hdl/lbd_lane.sv @@
// One bit-serial restoring divider lane: value / divisor, one quotient bit a cycle while shift is set.
// Depends on lbd_pkg.
module lbd_lane #(
    parameter int VALUE_BITS = 64,
    parameter int BASE_BITS  = 32
) (
    input  logic                      clk,
    input  lbd_pkg::lbd_lane_ctl_t    ctl,
    input  logic [VALUE_BITS-1:0]     load_value,
    input  logic [BASE_BITS-1:0]      divisor,
    output logic [VALUE_BITS-1:0]     value,
    output logic [BASE_BITS-1:0]      remainder
);
    import lbd_pkg::*;

    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [BASE_BITS-1:0]  rem_reg, rem_next;
    logic [BASE_BITS:0]    trial;
    logic [BASE_BITS:0]    diff;
    logic                  ge;

    // Dividend shifts out at the top, quotient bits fill in at the bottom
    assign trial = {rem_reg, val_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = (trial >= {1'b0, divisor});

    always_comb
    begin
        val_next = val_reg;
        rem_next = rem_reg;
        priority if (ctl.load)
        begin
            val_next = load_value;
            rem_next = '0;
        end
        else if (ctl.clear)
        begin
            rem_next = '0;
        end
        else if (ctl.shift)
        begin
            val_next = {val_reg[VALUE_BITS-2:0], ge};
            rem_next = ge ? diff[BASE_BITS-1:0] : trial[BASE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
    end

    assign value     = val_reg;
    assign remainder = rem_reg;
endmodule

@@ hdl/lbd_core.sv @@
// Digit sequencer: runs both values through serial dividers digit by digit
// and compares remainders. Depends on lbd_pkg and lbd_lane.
module lbd_core #(
    parameter int VALUE_BITS = 64,
    parameter int BASE_BITS  = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [VALUE_BITS-1:0]     upper_value,
    input  logic [VALUE_BITS-1:0]     lower_value,
    input  logic [BASE_BITS-1:0]      base,
    input  logic                      ack,
    output lbd_pkg::lbd_status_t      status
);
    import lbd_pkg::*;

    localparam int CNT_BITS = $clog2(VALUE_BITS);

    lbd_state_t            state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  result_reg, result_next;
    lbd_lane_ctl_t         ctl;
    logic [VALUE_BITS-1:0] m_val, t_val;
    logic [BASE_BITS-1:0]  m_rem, t_rem;

    lbd_lane #(.VALUE_BITS(VALUE_BITS), .BASE_BITS(BASE_BITS)) u_lane_m (
        .clk        (clk),
        .ctl        (ctl),
        .load_value (upper_value),
        .divisor    (base),
        .value      (m_val),
        .remainder  (m_rem)
    );

    lbd_lane #(.VALUE_BITS(VALUE_BITS), .BASE_BITS(BASE_BITS)) u_lane_t (
        .clk        (clk),
        .ctl        (ctl),
        .load_value (lower_value),
        .divisor    (base),
        .value      (t_val),
        .remainder  (t_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            result_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        ctl         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // Remainders hold the digit just produced (zero right after load)
                if (t_rem > m_rem)
                begin
                    result_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (m_val == '0 && t_val == '0)
                begin
                    result_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    ctl.clear  = 1'b1;
                    cnt_next   = CNT_BITS'(VALUE_BITS - 1);
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                ctl.shift = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign status.idle   = (state_reg == ST_IDLE);
    assign status.done   = (state_reg == ST_DONE);
    assign status.result = result_reg;
endmodule

@@ hdl/lucas_binomial_divisibility_top.sv @@
// Lucas divisibility test: one item at a time, one base-p digit per pass of
// a bit-serial divider, at most VALUE_BITS digits examined; a new input beat
// is taken only once the core is idle again, after the previous result has
// moved into the output register. The time per item is set by the serial
// divider passes.
// rst_n is asynchronous active low; digit_base resets to 2.
`include "lucas_binomial_divisibility_top_defines.svh"

module lucas_binomial_divisibility_top #(
    parameter int VALUE_BITS = 64,
    parameter int BASE_BITS  = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  logic [lbd_pkg::CFG_W-1:0]          cfg_wdata,    // digit_base
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [lbd_pkg::IN_TDATA_W-1:0]     s_axis_tdata, // upper_value, lower_value
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [lbd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata  // divisible, zero pad
);
    import lbd_pkg::*;

    logic [BASE_BITS-1:0] base_reg, base_next;
    logic [BASE_BITS-1:0] base_eff;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_bit_reg, out_bit_next;
    logic                 start;
    logic                 out_load;
    lbd_status_t          status;

    always_comb
    begin
        base_next = cfg_wen ? BASE_BITS'(cfg_wdata) : base_reg;
    end

    // Base 0 or 1 behaves as base 2
    assign base_eff = (base_reg < BASE_BITS'(2)) ? BASE_BITS'(2) : base_reg;

    assign s_axis_tready = status.idle;
    assign start         = s_axis_tvalid & s_axis_tready;
    assign out_load      = status.done & (~out_valid_reg | m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
            out_bit_next   = status.result;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= BASE_BITS'(2);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_bit_reg <= out_bit_next;
    end

    lbd_core #(.VALUE_BITS(VALUE_BITS), .BASE_BITS(BASE_BITS)) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .upper_value (s_axis_tdata[VALUE_BITS-1:0]),
        .lower_value (s_axis_tdata[FIELD_W+VALUE_BITS-1:FIELD_W]),
        .base        (base_eff),
        .ack         (out_load),
        .status      (status)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_bit_reg};

    `LBD_ASSERT_NEXT(a_start_busy, clk, rst_n, start, !status.idle, "core idle after accepted beat")
    `LBD_ASSERT_NEXT(a_done_hold, clk, rst_n, status.done && !out_load, status.done && $stable(status.result), "finished result dropped while output busy")
    `LBD_ASSERT_NEXT(a_out_load, clk, rst_n, out_load, m_axis_tvalid && m_axis_tdata[0] == $past(status.result), "output register missed result")
endmodule

@@ dv/lucas_binomial_divisibility_top_tb.sv @@
// Self-checking testbench for lucas_binomial_divisibility_top: digit-wise Lucas test of (m, t)
// against a programmable radix, with random valid gaps on the input and random back-pressure on the output.
// Depends on lbd_pkg and the RTL top level only.
module lucas_binomial_divisibility_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbd_pkg::*;

    localparam int IDLE_MAX    = 12;
    localparam int QUIET_LIMIT = 30000;   // several times the worst-case item time
    localparam int TAIL_CYCLES = 4200;
    localparam int PHASE_ITEMS = 13;
    localparam logic [FIELD_W-1:0] ALL_ONES = '1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wen = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // upper_value [63:0], lower_value [127:64]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // divisible [0], zero pad

    logic [CFG_W-1:0] cur_base = CFG_W'(2);
    logic             hit_q[$];
    bit               in_gaps = 1'b0;
    bit               out_gaps = 1'b0;
    int               out_stall = 0;
    int               err_count = 0;
    int               items_sent = 0;
    int               hits_seen = 0;
    int               base_writes = 0;
    int               quiet_cycles = 0;

    lucas_binomial_divisibility_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    function automatic logic [FIELD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [FIELD_W-1:0] radix_of(input logic [CFG_W-1:0] base);
        return (base < 2) ? FIELD_W'(2) : FIELD_W'(base);
    endfunction

    // 1 when some base-p digit of t is above the matching digit of m
    function automatic logic digit_hit(input logic [CFG_W-1:0] base,
                                       input logic [FIELD_W-1:0] m,
                                       input logic [FIELD_W-1:0] t);
        logic [FIELD_W-1:0] p;
        logic [FIELD_W-1:0] mr;
        logic [FIELD_W-1:0] tr;
        p = radix_of(base);
        mr = m;
        tr = t;
        for (int i = 0; i < FIELD_W; i++)
        begin
            if (mr == 0 && tr == 0)
                break;
            if (tr % p > mr % p)
                return 1'b1;
            mr = mr / p;
            tr = tr / p;
        end
        return 1'b0;
    endfunction

    // random t whose digits never exceed those of m (no hit)
    function automatic logic [FIELD_W-1:0] digit_subset(input logic [CFG_W-1:0] base,
                                                        input logic [FIELD_W-1:0] m);
        logic [FIELD_W-1:0] p;
        logic [FIELD_W-1:0] mr;
        logic [FIELD_W-1:0] pw;
        logic [FIELD_W-1:0] t;
        logic [FIELD_W-1:0] d;
        p = radix_of(base);
        mr = m;
        pw = 1;
        t = 0;
        while (mr != 0)
        begin
            d = mr % p;
            t = t + (rand64() % (d + 1)) * pw;
            mr = mr / p;
            pw = pw * p;
        end
        return t;
    endfunction

    task automatic send_pair(input logic [FIELD_W-1:0] m, input logic [FIELD_W-1:0] t);
        int gap;
        logic hit;
        gap = in_gaps ? $urandom_range(0, IDLE_MAX) : 0;
        hit = digit_hit(cur_base, m, t);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {t, m};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        hit_q.insert(hit_q.size(), hit);
        items_sent++;
        if (hit)
            hits_seen++;
    endtask

    // sender holds off until every outstanding result is back
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (hit_q.size() != 0)
            @(posedge clk);
    endtask

    // only called with the block idle
    task automatic write_base(input logic [CFG_W-1:0] base);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= base;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        cur_base = base;
        base_writes++;
    endtask

    task automatic test_reset_base();
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        send_pair(64'd0, 64'd0);
        send_pair(ALL_ONES, ALL_ONES);
        send_pair(ALL_ONES, 64'd0);
        send_pair(64'd0, ALL_ONES);
        send_pair(64'd5, 64'd3);
        send_pair(64'd7, 64'd3);
        send_pair(64'd6, 64'd4);
        send_pair(64'd8, 64'd7);
        wait_drained();
    endtask

    // 0 and 1 fall back to radix 2
    task automatic test_small_bases();
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
        write_base(CFG_W'(0));
        send_pair(64'd10, 64'd5);
        send_pair(64'd15, 64'd5);
        wait_drained();
        write_base(CFG_W'(1));
        send_pair(64'd4, 64'd2);
        send_pair(64'd3, 64'd1);
        wait_drained();
        write_base(CFG_W'(3));
        send_pair(64'd4, 64'd2);
        send_pair(64'd4, 64'd1);
        send_pair(64'd9, 64'd3);
        send_pair(ALL_ONES, ALL_ONES);
        wait_drained();
    endtask

    task automatic test_wide_base();
        in_gaps  = 1'b1;
        out_gaps = 1'b0;
        write_base('1);
        send_pair(ALL_ONES, 64'h1234_5678_9abc_def0);
        send_pair(64'hffff_fffe, 64'hffff_ffff);
        send_pair(64'h1_0000_0000, 64'd1);
        send_pair(ALL_ONES, ALL_ONES);
        wait_drained();
        write_base(CFG_W'(32'h8000_0000));
        send_pair(ALL_ONES, 64'd0);
        send_pair(64'd0, 64'd1);
        wait_drained();
    endtask

    task automatic test_random_pairs();
        logic [CFG_W-1:0]   bases[9];
        logic [FIELD_W-1:0] m;
        logic [FIELD_W-1:0] t;
        int kind;
        int shift;
        bases = '{CFG_W'(2), CFG_W'(3), '1, CFG_W'(7), $urandom, CFG_W'(1),
                  CFG_W'(0), CFG_W'(65521), CFG_W'(5)};
        foreach (bases[ph])
        begin
            write_base(bases[ph]);
            // first phase runs with no idling at all
            in_gaps  = (ph == 0) ? 1'b0 : (ph % 3 != 1);
            out_gaps = (ph == 0) ? 1'b0 : (ph % 3 != 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                kind = $urandom_range(0, 9);
                shift = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 63);
                m = rand64() >> shift;
                if (kind < 5)
                    t = digit_subset(cur_base, m);
                else if (kind < 7)
                    t = digit_subset(cur_base, m) ^ (64'd1 << $urandom_range(0, 63));
                else if (kind == 7)
                    t = m + 1 + (rand64() >> $urandom_range(1, 63));
                else
                    t = rand64() >> $urandom_range(0, 63);
                send_pair(m, t);
                // mid-phase drain now and then
                if ($urandom_range(0, 15) == 0)
                    wait_drained();
            end
            wait_drained();
        end
    endtask

    // result side: ready held low while the drawn stall count runs out
    always @(negedge clk)
    begin
        m_axis_tready <= (out_stall == 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (hit_q.size() == 0)
            begin
                $error("unexpected result beat: divisible actual %0d", m_axis_tdata[0]);
                err_count++;
            end
            else
            begin
                if (m_axis_tdata[0] !== hit_q[0])
                begin
                    $error("divisible mismatch: expected %0d actual %0d",
                           hit_q[0], m_axis_tdata[0]);
                    err_count++;
                end
                void'(hit_q.pop_front());
            end
            out_stall = out_gaps ? $urandom_range(0, IDLE_MAX) : 0;
        end
        else if (m_axis_tvalid && !m_axis_tready && out_stall > 0)
        begin
            // stall cycles are spent only while a result is offered
            out_stall--;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout after %0d cycles with no beat", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_base();
        test_small_bases();
        test_wide_base();
        test_random_pairs();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (hit_q.size() != 0)
        begin
            $error("%0d results never arrived", hit_q.size());
            err_count++;
        end
        $display("ran %0d (m, t) pairs, %0d expected hits, over %0d radix writes",
                 items_sent, hits_seen, base_writes);
        $display("radix extremes 0, 1, 2, 3 and 2^32-1 covered; errors: %0d", err_count);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
